### hw/rtl/gf2m_inverse_euclid_unit_defines.svh
// Assertion macros for the GF(2^m) inverse unit.
`ifndef GF2M_INVERSE_EUCLID_UNIT_DEFINES_SVH
`define GF2M_INVERSE_EUCLID_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define GIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define GIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gie_pkg.sv
// Shared types and status codes for the GF(2^m) inverse unit.
package gie_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOINV = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

### hw/rtl/gie_step.sv
// One registered reduction step of the extended Euclidean pipeline.
module gie_step #(
  parameter int W = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  gie_pkg::ctl_t ctl_in,
  input  logic [W-1:0]  r1_in,
  input  logic [W-1:0]  r2_in,
  input  logic [W-1:0]  t1_in,
  input  logic [W-1:0]  t2_in,
  output gie_pkg::ctl_t ctl,
  output logic [W-1:0]  r1,
  output logic [W-1:0]  r2,
  output logic [W-1:0]  t1,
  output logic [W-1:0]  t2
);
  import gie_pkg::*;

  localparam int DW = $clog2(W + 1);

  function automatic logic [DW-1:0] lvl(input logic [W-1:0] p);
    logic [DW-1:0] l;
    l = '0;
    for (int i = 0; i < W; i++) begin
      if (p[i]) l = DW'(i + 1);
    end
    return l;
  endfunction

  logic [DW-1:0] l1, l2, la1, la2, sh;
  logic          swap;
  logic [W-1:0]  a1, a2, at1, at2;
  logic [W-1:0]  r1_next, t1_next;

  always_comb begin
    l1   = lvl(r1_in);
    l2   = lvl(r2_in);
    swap = l1 < l2;
    a1   = swap ? r2_in : r1_in;
    a2   = swap ? r1_in : r2_in;
    at1  = swap ? t2_in : t1_in;
    at2  = swap ? t1_in : t2_in;
    la1  = swap ? l2 : l1;
    la2  = swap ? l1 : l2;
    sh   = la1 - la2;
    if (la2 != '0) begin
      r1_next = a1 ^ (a2 << sh);
      t1_next = at1 ^ (at2 << sh);
    end else begin
      r1_next = a1;
      t1_next = at1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    r1 <= r1_next;
    r2 <= a2;
    t1 <= t1_next;
    t2 <= at2;
  end

endmodule

### hw/rtl/gf2m_inverse_euclid_unit.sv
// Top level: pipelined GF(2^m) inverse by the extended Euclidean algorithm.
// Throughput: one operand per cycle; busy stays low, the receiver never stalls.
// Latency is set by the input register, 2*DEGREE+1 step stages and the output register.
// Synchronous active-high reset clears valid bits and loads the modulus reset value.
module gf2m_inverse_euclid_unit #(
  parameter int DEGREE        = 10,
  parameter int MODULUS_RESET = 1033
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [DEGREE-1:0]   operand,
  output logic                done,
  output logic [DEGREE-1:0]   inverse,
  output logic [1:0]          status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DEGREE:0]     modulus_poly
);
  import gie_pkg::*;
  `include "gf2m_inverse_euclid_unit_defines.svh"

  localparam int W      = DEGREE + 1;
  localparam int NSTAGE = 2 * DEGREE + 1;
  localparam int LAT    = NSTAGE + 2;

  logic [W-1:0] modulus;
  ctl_t         ctl_s [NSTAGE+1];
  logic [W-1:0] r1_s  [NSTAGE+1];
  logic [W-1:0] r2_s  [NSTAGE+1];
  logic [W-1:0] t1_s  [NSTAGE+1];
  logic [W-1:0] t2_s  [NSTAGE+1];
  logic         accept;
  status_t      status_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(MODULUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      modulus <= modulus_poly;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else begin
      ctl_s[0].valid <= accept;
      ctl_s[0].zero  <= operand == '0;
    end
  end

  always_ff @(posedge clk) begin
    r1_s[0] <= modulus;
    r2_s[0] <= {1'b0, operand};
    t1_s[0] <= '0;
    t2_s[0] <= W'(1);
  end

  for (genvar k = 0; k < NSTAGE; k++) begin : g_step
    gie_step #(.W(W)) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_s[k]),
      .r1_in  (r1_s[k]),
      .r2_in  (r2_s[k]),
      .t1_in  (t1_s[k]),
      .t2_in  (t2_s[k]),
      .ctl    (ctl_s[k+1]),
      .r1     (r1_s[k+1]),
      .r2     (r2_s[k+1]),
      .t1     (t1_s[k+1]),
      .t2     (t2_s[k+1])
    );
  end

  always_comb begin
    priority if (ctl_s[NSTAGE].zero) begin
      status_next = ST_ZERO;
    end else if (r1_s[NSTAGE] == W'(1)) begin
      status_next = ST_OK;
    end else begin
      status_next = ST_NOINV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_s[NSTAGE].valid;
    end
  end

  always_ff @(posedge clk) begin
    status  <= status_next;
    inverse <= (status_next == ST_OK) ? t1_s[NSTAGE][DEGREE-1:0] : '0;
  end

  `GIE_ASSERT_NOW(a_latency, accept, ##(LAT) done, "result strobe missing after accept")
  `GIE_ASSERT_NOW(a_status_code, done,
    status == ST_OK || status == ST_ZERO || status == ST_NOINV, "bad status code")
  `GIE_ASSERT_NOW(a_zero_on_fail, done && status != ST_OK, inverse == '0,
    "nonzero inverse on failure")
  `GIE_ASSERT_NEXT(a_zero_operand, accept && operand == '0, ctl_s[0].zero,
    "zero operand flag lost")

endmodule
